// ===== sv/crc32_with_length_trailer_unit_defines.svh =====
// assertion macros for the top unit, which checks its own logic
`ifndef CRC32_WITH_LENGTH_TRAILER_UNIT_DEFINES_SVH
`define CRC32_WITH_LENGTH_TRAILER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CRC32LT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("crc32lt assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CRC32LT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("crc32lt assertion failed");

`endif

// ===== sv/crc32lt_pkg.sv =====
`default_nettype none
package crc32lt_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_SEED = 32'hFFFFFFFF;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] checksum;
		logic [63:0] message_length;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic fold_data;
		logic start_len;
		logic fold_len;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rest_zero;
	} status_t;

	// one byte through the reflected crc, bit at a time
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = {24'h0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c ^ (crc >> 8);
	endfunction

endpackage
`default_nettype wire

// ===== sv/crc32_with_length_trailer_unit.sv =====
// data beats: one per cycle while not stalled, no result, folded into the crc at the accepting edge
// finish beat: the k nonzero-length bytes (0..8) are folded, then the result is loaded once the output is free
// input is stalled from the finish beat until the result is loaded
// a waiting result does not block the data beats of the next message
// reset (arst_n low, asynchronous): crc all ones, count zero, idle, no result pending
`default_nettype none
module crc32_with_length_trailer_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire crc32lt_pkg::item_t   item,
	output logic                      sum_valid,
	input  wire logic                 sum_stall,
	output crc32lt_pkg::result_t      sum
);
	import crc32lt_pkg::*;

	`include "crc32_with_length_trailer_unit_defines.svh"

	// command and status between the sequencer and the datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: idle takes beats, length state walks the count bytes
	crc32lt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_opcode (item.opcode),
		.item_stall  (item_stall),
		.sum_valid   (sum_valid),
		.sum_stall   (sum_stall),
		.status      (status),
		.cmd         (cmd)
	);

	// datapath: crc, byte count, length shifter and result register
	crc32lt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (item.data_byte),
		.cmd       (cmd),
		.status    (status),
		.result    (sum)
	);

	// a finish beat always puts the block into the length walk
	`CRC32LT_ASSERT_NEXT(a_finish_busy, clk, arst_n,
		item_valid && !item_stall && item.opcode == OP_FINISH, item_stall)
	// a new result only appears out of the length walk
	`CRC32LT_ASSERT_NOW(a_result_from_walk, clk, arst_n, $rose(sum_valid), $past(item_stall))
	// empty message gives the inverse of the start value
	`CRC32LT_ASSERT_NOW(a_empty_zero, clk, arst_n,
		sum_valid && sum.message_length == 64'd0, sum.checksum == 32'd0)

endmodule
`default_nettype wire

// ===== sv/crc32lt_ctrl.sv =====
`default_nettype none
module crc32lt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic               item_opcode,
	output logic                    item_stall,
	output logic                    sum_valid,
	input  wire logic               sum_stall,
	input  wire crc32lt_pkg::status_t status,
	output crc32lt_pkg::cmd_t       cmd
);
	import crc32lt_pkg::*;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_LEN  = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !sum_stall;
	assign sum_valid  = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item_opcode == OP_DATA) begin
					cmd.fold_data = 1'b1;
				end else if (accept && item_opcode == OP_FINISH) begin
					cmd.start_len = 1'b1;
					state_d       = S_LEN;
				end
			end
			S_LEN: begin
				if (!status.rest_zero) begin
					cmd.fold_len = 1'b1;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!sum_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/crc32lt_dp.sv =====
`default_nettype none
module crc32lt_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           data_byte,
	input  wire crc32lt_pkg::cmd_t    cmd,
	output crc32lt_pkg::status_t      status,
	output crc32lt_pkg::result_t      result
);
	import crc32lt_pkg::*;

	logic [31:0] crc_q;
	logic [63:0] count_q;
	logic [63:0] rest_q;
	result_t     res_q;

	assign status.rest_zero = (rest_q == 64'd0);
	assign result           = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_SEED;
			count_q <= 64'd0;
		end else begin
			if (cmd.fold_data) begin
				crc_q   <= crc_fold(crc_q, data_byte);
				count_q <= count_q + 64'd1;
			end else if (cmd.fold_len) begin
				crc_q <= crc_fold(crc_q, rest_q[7:0]);
			end else if (cmd.emit) begin
				crc_q   <= CRC_SEED;
				count_q <= 64'd0;
			end
		end
	end

	// length bytes, low byte first
	always_ff @(posedge clk) begin
		if (cmd.start_len) begin
			rest_q <= count_q;
		end else if (cmd.fold_len) begin
			rest_q <= rest_q >> 8;
		end
		if (cmd.emit) begin
			res_q.checksum       <= ~crc_q;
			res_q.message_length <= count_q;
		end
	end

endmodule
`default_nettype wire
